FILE: hw/rtl/upc_pkg.sv
// ----------------------------------------------------------------------------
// upc_pkg: shared types and helpers for the URL path canonicaliser
// Request and result structs, the front-to-back command format, character
// constants and the small character-class functions used by both halves.
// ----------------------------------------------------------------------------
package upc_pkg;

  // Input request: one raw byte of the target
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Result: one path character or the final verdict
  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       done_res;
    logic       path_ok;
  } out_item_t;

  // What the back end must emit for one accepted byte
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_PLAIN = 2'd1,
    CMD_ESC   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic       done;
    logic       ok;
  } cmd_t;

  // Command queue geometry
  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int CMD_QUEUE_AW    = $clog2(CMD_QUEUE_DEPTH);

  // Register reset values
  localparam logic [15:0] MAX_TARGET_RESET  = 16'd8192;
  localparam logic [11:0] MAX_SEGMENT_RESET = 12'd1024;

  // Character constants
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_QUERY   = 8'h3F;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7F;

  // Uppercase hex digit for a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + {4'd0, n};
    end
    return 8'h37 + {4'd0, n};
  endfunction

  // Hex digit value: bit 4 set when the byte is a valid digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      return {1'b1, c[3:0] + 4'd9};
    end
    return 5'd0;
  endfunction

  // Unreserved characters pass through unescaped
  function automatic logic keep_plain(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == CH_DOT ||
           c == 8'h5F || c == 8'h7E;
  endfunction

endpackage

FILE: hw/rtl/upc_front.sv
// ----------------------------------------------------------------------------
// upc_front: byte parser and validator
// Accepts one raw byte per cycle unless the queue is full, tracks escape,
// segment, dot and UTF-8 state, and issues one command per output or last byte.
// ----------------------------------------------------------------------------
module upc_front
  import upc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_req,
  input  logic [15:0] max_target_length,
  input  logic [11:0] max_segment_length,
  output logic        q_push,
  output cmd_t        q_cmd,
  input  logic        q_full
);

  typedef enum logic [2:0] {
    PH_SLASH = 3'b001,
    PH_PATH  = 3'b010,
    PH_QUERY = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ESC_NONE = 3'b001,
    ESC_PCT  = 3'b010,
    ESC_HI   = 3'b100
  } esc_t;

  localparam logic [1:0] DOT_EMPTY = 2'd0;
  localparam logic [1:0] DOT_ONE   = 2'd1;
  localparam logic [1:0] DOT_TWO   = 2'd2;
  localparam logic [1:0] DOT_OTHER = 2'd3;

  localparam logic [2:0] U8_NONE = 3'd0;
  localparam logic [2:0] U8_A0BF = 3'd1;
  localparam logic [2:0] U8_809F = 3'd2;
  localparam logic [2:0] U8_90BF = 3'd3;
  localparam logic [2:0] U8_808F = 3'd4;

  phase_t      phase, phase_next;
  esc_t        esc, esc_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [11:0] seg_count, seg_count_next;
  logic [1:0]  dot, dot_next;
  logic [1:0]  u8_pending, u8_pending_next;
  logic [2:0]  u8_limit, u8_limit_next;
  logic [15:0] tgt_count, tgt_count_next;
  logic        err, err_next;

  cmd_kind_t   kind;
  logic [7:0]  ch;
  logic        ok;
  logic        accept;

  // Segment end is bad on an open escape, empty, dot segments or open UTF-8
  function automatic logic seg_bad(input esc_t e, input logic [11:0] cnt,
                                   input logic [1:0] dp, input logic [1:0] pend);
    return (e != ESC_NONE) || (cnt == 12'd0) || (dp == DOT_ONE) ||
           (dp == DOT_TWO) || (pend != 2'd0);
  endfunction

  assign full   = q_full;
  assign accept = push && !q_full;

  // Next state for the byte on the input
  always_comb begin
    logic       take;
    logic [7:0] b;
    logic [7:0] d;
    logic [4:0] hv;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       u8_ok;

    phase_next       = phase;
    esc_next         = esc;
    high_nibble_next = high_nibble;
    seg_count_next   = seg_count;
    dot_next         = dot;
    u8_pending_next  = u8_pending;
    u8_limit_next    = u8_limit;
    tgt_count_next   = tgt_count;
    err_next         = err;
    kind             = CMD_NONE;
    ch               = CH_SLASH;
    take             = 1'b0;
    b                = in_req.in_byte;
    d                = b;
    hv               = hex_value(b);
    lo               = 8'h80;
    hi               = 8'hBF;
    u8_ok            = 1'b0;

    // Raw length and fragment checks
    if (tgt_count >= max_target_length) begin
      err_next = 1'b1;
    end else if (tgt_count != 16'hFFFF) begin
      tgt_count_next = tgt_count + 16'd1;
    end
    if (b == CH_HASH) begin
      err_next = 1'b1;
    end

    // Parse the byte
    if (phase == PH_SLASH) begin
      if (b != CH_SLASH) begin
        err_next = 1'b1;
      end else if (!err_next) begin
        kind = CMD_PLAIN;
      end
      phase_next       = PH_PATH;
      esc_next         = ESC_NONE;
      high_nibble_next = 4'd0;
      seg_count_next   = 12'd0;
      dot_next         = DOT_EMPTY;
      u8_pending_next  = 2'd0;
      u8_limit_next    = U8_NONE;
    end else if (phase == PH_PATH && !err_next) begin
      if (b == CH_SLASH || b == CH_QUERY) begin
        if (seg_bad(esc, seg_count, dot, u8_pending)) begin
          err_next = 1'b1;
        end
        if (b == CH_SLASH) begin
          if (!err_next) begin
            kind = CMD_PLAIN;
          end
          esc_next         = ESC_NONE;
          high_nibble_next = 4'd0;
          seg_count_next   = 12'd0;
          dot_next         = DOT_EMPTY;
          u8_pending_next  = 2'd0;
          u8_limit_next    = U8_NONE;
        end else begin
          phase_next = PH_QUERY;
        end
      end else if (esc == ESC_NONE) begin
        if (b == CH_PERCENT) begin
          esc_next = ESC_PCT;
        end else if (b <= CH_SPACE || b == CH_DEL || b == CH_BSLASH) begin
          err_next = 1'b1;
        end else begin
          take = 1'b1;
        end
      end else begin
        if (!hv[4]) begin
          err_next = 1'b1;
        end else if (esc == ESC_PCT) begin
          high_nibble_next = hv[3:0];
          esc_next         = ESC_HI;
        end else begin
          esc_next = ESC_NONE;
          take     = 1'b1;
          d        = {high_nibble, hv[3:0]};
        end
      end
    end

    // Take one decoded byte into the segment
    if (take) begin
      if (seg_count >= max_segment_length) begin
        err_next = 1'b1;
      end else begin
        if (seg_count != 12'hFFF) begin
          seg_count_next = seg_count + 12'd1;
        end
        if (d == 8'h00) begin
          err_next = 1'b1;
        end else begin
          if (d == CH_DOT) begin
            if (dot != DOT_OTHER) begin
              dot_next = dot + 2'd1;
            end
          end else begin
            dot_next = DOT_OTHER;
          end
          // Strict UTF-8 sequence check
          if (u8_pending != 2'd0) begin
            priority case (u8_limit)
              U8_A0BF: lo = 8'hA0;
              U8_809F: hi = 8'h9F;
              U8_90BF: lo = 8'h90;
              U8_808F: hi = 8'h8F;
              default: ;
            endcase
            u8_ok = (d >= lo) && (d <= hi);
            if (u8_ok) begin
              u8_limit_next   = U8_NONE;
              u8_pending_next = u8_pending - 2'd1;
            end
          end else if (d < 8'h80) begin
            u8_ok = 1'b1;
          end else if (d >= 8'hC2 && d <= 8'hDF) begin
            u8_ok           = 1'b1;
            u8_pending_next = 2'd1;
          end else if (d >= 8'hE0 && d <= 8'hEF) begin
            u8_ok           = 1'b1;
            u8_pending_next = 2'd2;
            u8_limit_next   = (d == 8'hE0) ? U8_A0BF : (d == 8'hED) ? U8_809F : U8_NONE;
          end else if (d >= 8'hF0 && d <= 8'hF4) begin
            u8_ok           = 1'b1;
            u8_pending_next = 2'd3;
            u8_limit_next   = (d == 8'hF0) ? U8_90BF : (d == 8'hF4) ? U8_808F : U8_NONE;
          end
          if (!u8_ok) begin
            err_next = 1'b1;
          end else begin
            kind = keep_plain(d) ? CMD_PLAIN : CMD_ESC;
            ch   = d;
          end
        end
      end
    end

    // Verdict for a final byte
    ok = !(err_next || (phase_next == PH_PATH &&
           seg_bad(esc_next, seg_count_next, dot_next, u8_pending_next)));
  end

  // Issue a command whenever the byte yields characters or ends the target
  assign q_push     = accept && (kind != CMD_NONE || in_req.in_last);
  assign q_cmd.kind = kind;
  assign q_cmd.ch   = ch;
  assign q_cmd.done = in_req.in_last;
  assign q_cmd.ok   = ok;

  // Hold parser state; clear it at the end of each target
  always_ff @(posedge clk) begin
    if (rst || (accept && in_req.in_last)) begin
      phase       <= PH_SLASH;
      esc         <= ESC_NONE;
      high_nibble <= 4'd0;
      seg_count   <= 12'd0;
      dot         <= DOT_EMPTY;
      u8_pending  <= 2'd0;
      u8_limit    <= U8_NONE;
      tgt_count   <= 16'd0;
      err         <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      esc         <= esc_next;
      high_nibble <= high_nibble_next;
      seg_count   <= seg_count_next;
      dot         <= dot_next;
      u8_pending  <= u8_pending_next;
      u8_limit    <= u8_limit_next;
      tgt_count   <= tgt_count_next;
      err         <= err_next;
    end
  end

endmodule

FILE: hw/rtl/upc_fifo.sv
// ----------------------------------------------------------------------------
// upc_fifo: command queue between front and back
// Small synchronous queue of commands; lets the parser run ahead while
// the emitter spells out escapes.
// ----------------------------------------------------------------------------
module upc_fifo
  import upc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t                    mem [CMD_QUEUE_DEPTH];
  logic [CMD_QUEUE_AW-1:0] wr_ptr;
  logic [CMD_QUEUE_AW-1:0] rd_ptr;
  logic [CMD_QUEUE_AW:0]   count;
  logic                    do_push;
  logic                    do_pop;

  assign full    = (count == (CMD_QUEUE_AW + 1)'(CMD_QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/upc_back.sv
// ----------------------------------------------------------------------------
// upc_back: result emitter
// Holds one command and spells it out as results: a plain character, or
// '%' and two uppercase hex digits, then the verdict on the final byte.
// ----------------------------------------------------------------------------
module upc_back
  import upc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      q_cmd,
  input  logic      q_empty,
  output logic      q_pop,
  output out_item_t res,
  output logic      empty,
  input  logic      pop
);

  cmd_t       cur;
  logic       cur_valid;
  logic [1:0] step;
  logic [2:0] n_char;
  logic [2:0] n_total;
  logic       last_step;
  logic       advance;

  // Count the results owed by the held command
  always_comb begin
    unique case (cur.kind)
      CMD_PLAIN: n_char = 3'd1;
      CMD_ESC:   n_char = 3'd3;
      default:   n_char = 3'd0;
    endcase
  end

  assign n_total   = n_char + {2'd0, cur.done};
  assign last_step = ({1'b0, step} == n_total - 3'd1);
  assign empty     = !cur_valid;
  assign advance   = pop && cur_valid;
  assign q_pop     = !q_empty && (!cur_valid || (advance && last_step));

  // Present the current result
  always_comb begin
    res = '0;
    if ({1'b0, step} < n_char) begin
      res.char_valid = 1'b1;
      if (cur.kind == CMD_ESC) begin
        unique case (step)
          2'd0:    res.out_char = CH_PERCENT;
          2'd1:    res.out_char = hex_digit(cur.ch[7:4]);
          default: res.out_char = hex_digit(cur.ch[3:0]);
        endcase
      end else begin
        res.out_char = cur.ch;
      end
    end else begin
      res.done_res = 1'b1;
      res.path_ok  = cur.ok;
    end
  end

  // Hold the command payload; load the next one when idle or as the last result leaves
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
  end

  // Step through results
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= 2'd0;
    end else if (!cur_valid || (advance && last_step)) begin
      cur_valid <= !q_empty;
      step      <= 2'd0;
    end else if (advance) begin
      step <= step + 2'd1;
    end
  end

endmodule

FILE: hw/rtl/url_path_canonicalizer.sv
// ----------------------------------------------------------------------------
// url_path_canonicalizer: streaming request-target path canonicaliser
// Checks a request target byte by byte and emits its canonical path.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on push/full/in_req, one raw byte per request, in_last on
//   the final byte. Results leave on empty/pop/res: path characters first,
//   then one verdict result (done_res, path_ok) per target. The consumer
//   drops the characters of a target whose verdict has path_ok low.
//   With queue and emitter idle, the first result of a byte shows once its
//   command is written into the queue and loaded into the emitter.
//   Throughput: one request per cycle while the four-entry command queue is
//   not full; the emitter drains one result per cycle while the receiver
//   pops, so an escaped byte (three characters) takes three results and the
//   sustained rate is set by that single-result output port. When the
//   receiver stalls the queue fills and full rises; no result is lost. Reset
//   clears the parser, the queue and the emitter and sets the limits to 8192
//   target bytes and 1024 segment bytes. The limits sit at APB 0x0 and 0x4;
//   the user writes them only while the block is idle (not enforced here).
// ----------------------------------------------------------------------------
module url_path_canonicalizer
  import upc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_req,
  output logic        empty,
  input  logic        pop,
  output out_item_t   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] max_target_length;
  logic [11:0] max_segment_length;
  logic        cfg_write;
  logic        f_push;
  cmd_t        f_cmd;
  logic        f_full;
  cmd_t        b_cmd;
  logic        b_empty;
  logic        b_pop;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_target_length  <= MAX_TARGET_RESET;
      max_segment_length <= MAX_SEGMENT_RESET;
    end else if (cfg_write) begin
      if (paddr[2]) begin
        max_segment_length <= pwdata[11:0];
      end else begin
        max_target_length <= pwdata[15:0];
      end
    end
  end

  assign prdata = paddr[2] ? {20'd0, max_segment_length} : {16'd0, max_target_length};

  // Parser
  upc_front u_front (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .in_req             (in_req),
    .max_target_length  (max_target_length),
    .max_segment_length (max_segment_length),
    .q_push             (f_push),
    .q_cmd              (f_cmd),
    .q_full             (f_full)
  );

  // Command queue
  upc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_cmd),
    .full  (f_full),
    .pop   (b_pop),
    .dout  (b_cmd),
    .empty (b_empty)
  );

  // Emitter
  upc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (b_cmd),
    .q_empty (b_empty),
    .q_pop   (b_pop),
    .res     (res),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
